FILE: rtl/ihcf_pkg.sv
// IPv4 header checksum fixer: shared types and constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package ihcf_pkg;

  // Verdict codes as presented on the result channel
  typedef enum logic [2:0] {
    VERDICT_NON_IP    = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_MALFORMED = 3'd2,
    VERDICT_OK        = 3'd3,
    VERDICT_FIXED     = 3'd4
  } verdict_t;

  localparam int unsigned WORD_W      = 16;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CNT_IDX_W   = 6;
  localparam int unsigned HLEN_W      = 4;
  localparam int unsigned SUM_W       = 21;
  localparam int unsigned MIN_WORDS   = 10;
  localparam int unsigned CKS_WORD    = 5;
  localparam int unsigned IHL_MIN     = 5;

  // Packet finish event passed from the parser to the statistics block
  typedef struct packed {
    logic                fire;
    verdict_t            verdict;
    logic [WORD_W-1:0]   cks;
  } ihcf_event_t;

endpackage

`default_nettype wire

FILE: rtl/ipv4_header_checksum_fixer_core.sv
// IPv4 header checksum fixer top level: input register, parser, statistics
// and result register. Depends on ihcf_pkg, ihcf_hdr_parse and ihcf_stats.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   in      | sink      | in_valid, in_stall, in_op, in_first_word,
//           |           | in_hdr_word, in_data_ends
//   out     | source    | out_valid, out_stall, out_verdict, out_good_checksum,
//           |           | out_count_packets/ok/fixed/non_ip
//
// One header word per cycle while in_stall is low. The word that finishes a packet
// passes the input register, then the result register, where its result is valid.
// Rate is set by the single-pass sum and fold between the two registers.
// Reset (rst_n low, synchronous) empties both registers and zeroes counters.
// A stalled result holds the word in the input register; in_stall rises when
// both registers are occupied and out_stall is high.
`default_nettype none

module ipv4_header_checksum_fixer_core #(
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic                          in_first_word,
  input  wire logic [ihcf_pkg::WORD_W-1:0]   in_hdr_word,
  input  wire logic                          in_data_ends,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_verdict,
  output logic [ihcf_pkg::WORD_W-1:0]        out_good_checksum,
  output logic [COUNTER_WIDTH-1:0]           out_count_packets,
  output logic [COUNTER_WIDTH-1:0]           out_count_ok,
  output logic [COUNTER_WIDTH-1:0]           out_count_fixed,
  output logic [COUNTER_WIDTH-1:0]           out_count_non_ip
);
  import ihcf_pkg::*;

  logic              iv_r, iv_nxt;
  logic              op_r, first_r, ends_r;
  logic [WORD_W-1:0] word_r;
  logic              in_accept;
  logic              proc_en;
  ihcf_event_t       evt;

  logic                     ov_r, ov_nxt;
  verdict_t                 verdict_r;
  logic [WORD_W-1:0]        cks_r;
  logic [COUNTER_WIDTH-1:0] pk_r, ok_r, fx_r, ni_r;
  logic [COUNTER_WIDTH-1:0] pk_nxt, ok_nxt, fx_nxt, ni_nxt;

  // Process the held item whenever the result register can take a result
  assign proc_en   = !ov_r || !out_stall;
  assign in_stall  = iv_r && !proc_en;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    iv_nxt = iv_r;
    if (in_accept) begin
      iv_nxt = 1'b1;
    end else if (proc_en) begin
      iv_nxt = 1'b0;
    end
    ov_nxt = proc_en ? evt.fire : ov_r;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
    end
    if (in_accept) begin
      op_r    <= in_op;
      first_r <= in_first_word;
      word_r  <= in_hdr_word;
      ends_r  <= in_data_ends;
    end
  end

  ihcf_hdr_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_en    (iv_r && proc_en),
    .op         (op_r),
    .first_word (first_r),
    .hdr_word   (word_r),
    .data_ends  (ends_r),
    .evt        (evt)
  );

  ihcf_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt         (evt),
    .packets_nxt (pk_nxt),
    .ok_nxt      (ok_nxt),
    .fixed_nxt   (fx_nxt),
    .non_ip_nxt  (ni_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    if (proc_en && evt.fire) begin
      verdict_r <= evt.verdict;
      cks_r     <= evt.cks;
      pk_r      <= pk_nxt;
      ok_r      <= ok_nxt;
      fx_r      <= fx_nxt;
      ni_r      <= ni_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_verdict       = verdict_r;
  assign out_good_checksum = cks_r;
  assign out_count_packets = pk_r;
  assign out_count_ok      = ok_r;
  assign out_count_fixed   = fx_r;
  assign out_count_non_ip  = ni_r;

endmodule

`default_nettype wire

FILE: rtl/ihcf_hdr_parse.sv
// Header word parser: per-packet state, ones'-complement sum and verdict.
// Depends on ihcf_pkg.
`default_nettype none

module ihcf_hdr_parse (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          item_en,
  input  wire logic                          op,
  input  wire logic                          first_word,
  input  wire logic [ihcf_pkg::WORD_W-1:0]   hdr_word,
  input  wire logic                          data_ends,
  output ihcf_pkg::ihcf_event_t              evt
);
  import ihcf_pkg::*;

  logic [IDX_W-1:0]  word_idx_r, word_idx_nxt;
  logic [HLEN_W-1:0] hlen_r, hlen_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [WORD_W-1:0] stored_r, stored_nxt;
  logic              open_r, open_nxt;

  logic [IDX_W-1:0]     idx_eff;
  logic [SUM_W-1:0]     sum_eff;
  logic [WORD_W-1:0]    stored_eff;
  logic [SUM_W-1:0]     sum_acc;
  logic [WORD_W-1:0]    stored_acc;
  logic                 open_eff;
  logic [CNT_IDX_W-1:0] n_words;
  logic [CNT_IDX_W-1:0] need_words;
  logic [WORD_W:0]      fold1;
  logic [WORD_W:0]      fold2;
  logic [WORD_W-1:0]    cks;

  // Take the packet-start values, add the word (store it if it is the checksum word), then fold twice and invert
  always_comb begin
    open_eff   = first_word | open_r;
    idx_eff    = first_word ? '0 : word_idx_r;
    sum_eff    = first_word ? '0 : sum_r;
    stored_eff = first_word ? '0 : stored_r;

    if (idx_eff == IDX_W'(CKS_WORD)) begin
      stored_acc = hdr_word;
      sum_acc    = sum_eff;
    end else begin
      stored_acc = stored_eff;
      sum_acc    = sum_eff + SUM_W'(hdr_word);
    end

    fold1 = {1'b0, sum_acc[WORD_W-1:0]} + (WORD_W+1)'(sum_acc[SUM_W-1:WORD_W]);
    fold2 = {1'b0, fold1[WORD_W-1:0]} + (WORD_W+1)'(fold1[WORD_W]);
    cks   = ~fold2[WORD_W-1:0];
  end

  // Advance packet state and decide the verdict
  always_comb begin
    hlen_nxt   = first_word ? hdr_word[11:8] : hlen_r;
    stored_nxt = stored_acc;
    sum_nxt    = sum_acc;
    n_words    = {1'b0, idx_eff} + CNT_IDX_W'(1);
    need_words = {1'b0, hlen_nxt, 1'b0};

    word_idx_nxt = word_idx_r;
    open_nxt     = open_r;
    evt.fire     = 1'b0;
    evt.verdict  = VERDICT_NON_IP;
    evt.cks      = '0;

    if (!item_en) begin
      // hold all state
      hlen_nxt   = hlen_r;
      sum_nxt    = sum_r;
      stored_nxt = stored_r;
    end else if (op) begin
      evt.fire     = 1'b1;
      evt.verdict  = VERDICT_NON_IP;
      open_nxt     = 1'b0;
      word_idx_nxt = '0;
      hlen_nxt     = hlen_r;
      sum_nxt      = sum_r;
      stored_nxt   = stored_r;
    end else if (!open_eff) begin
      // drop a stray word outside any packet
      hlen_nxt   = hlen_r;
      sum_nxt    = sum_r;
      stored_nxt = stored_r;
    end else begin
      open_nxt = 1'b1;
      priority if (hlen_nxt < HLEN_W'(IHL_MIN) && n_words >= CNT_IDX_W'(MIN_WORDS)) begin
        evt.fire    = 1'b1;
        evt.verdict = VERDICT_MALFORMED;
      end else if (hlen_nxt >= HLEN_W'(IHL_MIN) && n_words >= need_words) begin
        evt.fire    = 1'b1;
        evt.verdict = (cks == stored_acc) ? VERDICT_OK : VERDICT_FIXED;
        evt.cks     = cks;
      end else if (data_ends) begin
        evt.fire    = 1'b1;
        evt.verdict = (n_words < CNT_IDX_W'(MIN_WORDS)) ? VERDICT_SHORT : VERDICT_MALFORMED;
      end else begin
        word_idx_nxt = n_words[IDX_W-1:0];
      end
      if (evt.fire) begin
        open_nxt     = 1'b0;
        word_idx_nxt = '0;
      end
    end
  end

  // Clear control state on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_idx_r <= '0;
      hlen_r     <= '0;
      sum_r      <= '0;
      stored_r   <= '0;
      open_r     <= 1'b0;
    end else begin
      word_idx_r <= word_idx_nxt;
      hlen_r     <= hlen_nxt;
      sum_r      <= sum_nxt;
      stored_r   <= stored_nxt;
      open_r     <= open_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ihcf_stats.sv
// Packet statistics: four wrapping counters; each finish event bumps packets and any that its verdict selects.
// Depends on ihcf_pkg; presents the counter values including this event.
`default_nettype none

module ihcf_stats #(
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ihcf_pkg::ihcf_event_t      evt,
  output logic [COUNTER_WIDTH-1:0]        packets_nxt,
  output logic [COUNTER_WIDTH-1:0]        ok_nxt,
  output logic [COUNTER_WIDTH-1:0]        fixed_nxt,
  output logic [COUNTER_WIDTH-1:0]        non_ip_nxt
);
  import ihcf_pkg::*;

  logic [COUNTER_WIDTH-1:0] packets_r, ok_r, fixed_r, non_ip_r;

  // Bump the counters that the verdict selects
  always_comb begin
    packets_nxt = packets_r;
    ok_nxt      = ok_r;
    fixed_nxt   = fixed_r;
    non_ip_nxt  = non_ip_r;
    if (evt.fire) begin
      packets_nxt = packets_r + COUNTER_WIDTH'(1);
      unique case (evt.verdict)
        VERDICT_NON_IP, VERDICT_MALFORMED: non_ip_nxt = non_ip_r + COUNTER_WIDTH'(1);
        VERDICT_OK:                        ok_nxt     = ok_r + COUNTER_WIDTH'(1);
        VERDICT_FIXED:                     fixed_nxt  = fixed_r + COUNTER_WIDTH'(1);
        default:                           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packets_r <= '0;
      ok_r      <= '0;
      fixed_r   <= '0;
      non_ip_r  <= '0;
    end else begin
      packets_r <= packets_nxt;
      ok_r      <= ok_nxt;
      fixed_r   <= fixed_nxt;
      non_ip_r  <= non_ip_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_ipv4_header_checksum_fixer_core.sv
// Self-checking testbench for ipv4_header_checksum_fixer_core: random and directed IPv4
// header word streams, an item-level verdict predictor and an in-order scoreboard.
// Depends on ihcf_pkg and the core RTL only.
module tb_ipv4_header_checksum_fixer_core;
  import ihcf_pkg::*;

  localparam int unsigned CW          = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 490;
  localparam int unsigned NUM_PHASES  = 4;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic              op;
    logic              first;
    logic [WORD_W-1:0] word;
    logic              ends;
  } hdr_item_t;

  typedef struct {
    verdict_t          verdict;
    logic [WORD_W-1:0] cks;
    logic [CW-1:0]     packets;
    logic [CW-1:0]     ok;
    logic [CW-1:0]     fixed;
    logic [CW-1:0]     non_ip;
  } verdict_rec_t;

  // DUT ports, all inputs known from time zero
  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_op         = 1'b0;
  logic              in_first_word = 1'b0;
  logic [WORD_W-1:0] in_hdr_word   = '0;
  logic              in_data_ends  = 1'b0;
  logic              out_stall     = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [2:0]        out_verdict;
  logic [WORD_W-1:0] out_good_checksum;
  logic [CW-1:0]     out_count_packets;
  logic [CW-1:0]     out_count_ok;
  logic [CW-1:0]     out_count_fixed;
  logic [CW-1:0]     out_count_non_ip;

  // Stimulus and scoreboard storage
  hdr_item_t    header_items[$];
  verdict_rec_t pending_verdicts[$];
  hdr_item_t    drv_item;
  int unsigned  sender_idle_pct = 0;
  int unsigned  recv_stall_pct  = 0;
  int unsigned  mismatch_count  = 0;
  int unsigned  words_sent      = 0;
  int unsigned  cycle_count     = 0;
  int unsigned  seen_verdicts[5] = '{default: 0};
  bit           gen_open        = 1'b0;

  // Predictor copy of the parser and statistics state
  logic [IDX_W-1:0]  hp_index   = '0;
  logic [HLEN_W-1:0] hp_ihl     = '0;
  logic [SUM_W-1:0]  hp_sum     = '0;
  logic [WORD_W-1:0] hp_stored  = '0;
  bit                hp_open    = 1'b0;
  logic [CW-1:0]     cnt_packets = '0;
  logic [CW-1:0]     cnt_ok      = '0;
  logic [CW-1:0]     cnt_fixed   = '0;
  logic [CW-1:0]     cnt_non_ip  = '0;

  ipv4_header_checksum_fixer_core #(.COUNTER_WIDTH(CW)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_first_word     (in_first_word),
    .in_hdr_word       (in_hdr_word),
    .in_data_ends      (in_data_ends),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict       (out_verdict),
    .out_good_checksum (out_good_checksum),
    .out_count_packets (out_count_packets),
    .out_count_ok      (out_count_ok),
    .out_count_fixed   (out_count_fixed),
    .out_count_non_ip  (out_count_non_ip)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count the packet, snapshot the counters and close the packet
  task automatic finish_packet(input verdict_t v, input logic [WORD_W-1:0] cks);
    verdict_rec_t rec;
    cnt_packets++;
    case (v)
      VERDICT_NON_IP, VERDICT_MALFORMED: cnt_non_ip++;
      VERDICT_OK:                        cnt_ok++;
      VERDICT_FIXED:                     cnt_fixed++;
      default: ;
    endcase
    rec.verdict = v;
    rec.cks     = cks;
    rec.packets = cnt_packets;
    rec.ok      = cnt_ok;
    rec.fixed   = cnt_fixed;
    rec.non_ip  = cnt_non_ip;
    pending_verdicts.push_back(rec);
    hp_open  = 1'b0;
    hp_index = '0;
  endtask

  // Advance the header parse by one accepted item
  task automatic track_header_word(input hdr_item_t it);
    logic [IDX_W:0]    n;
    logic [16:0]       fold1;
    logic [WORD_W-1:0] fold2;
    if (it.op) begin
      finish_packet(VERDICT_NON_IP, '0);
      return;
    end
    if (it.first) begin
      hp_open   = 1'b1;
      hp_index  = '0;
      hp_sum    = '0;
      hp_stored = '0;
      hp_ihl    = it.word[11:8];
    end
    // Ignore stray words outside a packet
    if (!hp_open) return;
    if (hp_index == CKS_WORD) hp_stored = it.word;
    else hp_sum = hp_sum + SUM_W'(it.word);
    n = {1'b0, hp_index} + (IDX_W+1)'(1);
    if (hp_ihl < IHL_MIN && n >= MIN_WORDS) begin
      finish_packet(VERDICT_MALFORMED, '0);
      return;
    end
    if (hp_ihl >= IHL_MIN && n >= {hp_ihl, 1'b0}) begin
      fold1 = {1'b0, hp_sum[15:0]} + 17'(hp_sum[SUM_W-1:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
      fold2 = ~fold2;
      finish_packet((fold2 == hp_stored) ? VERDICT_OK : VERDICT_FIXED, fold2);
      return;
    end
    if (it.ends) begin
      finish_packet((n < MIN_WORDS) ? VERDICT_SHORT : VERDICT_MALFORMED, '0);
      return;
    end
    hp_index = n[IDX_W-1:0];
  endtask

  // Compare one result against the oldest expectation
  task automatic check_verdict();
    verdict_rec_t rec;
    if (pending_verdicts.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0d: unexpected result verdict=%0d cks=%h pkts=%0d",
                 cycle_count, out_verdict, out_good_checksum, out_count_packets);
      return;
    end
    rec = pending_verdicts.pop_front();
    seen_verdicts[int'(rec.verdict)]++;
    if (out_verdict !== rec.verdict || out_good_checksum !== rec.cks ||
        out_count_packets !== rec.packets || out_count_ok !== rec.ok ||
        out_count_fixed !== rec.fixed || out_count_non_ip !== rec.non_ip) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0d: mismatch exp verdict=%0d cks=%h pkts=%0d ok=%0d fix=%0d nonip=%0d",
                 cycle_count, rec.verdict, rec.cks, rec.packets, rec.ok, rec.fixed,
                 rec.non_ip);
        $display("%0d:          got verdict=%0d cks=%h pkts=%0d ok=%0d fix=%0d nonip=%0d",
                 cycle_count, out_verdict, out_good_checksum, out_count_packets,
                 out_count_ok, out_count_fixed, out_count_non_ip);
      end
    end
  endtask

  // Reference ones'-complement header checksum, word 5 skipped
  function automatic logic [WORD_W-1:0] header_cks(input logic [WORD_W-1:0] w[$]);
    int unsigned acc;
    acc = 0;
    foreach (w[i]) if (i != CKS_WORD) acc += w[i];
    while (acc > 32'hffff) acc = (acc & 32'hffff) + (acc >> 16);
    return ~acc[WORD_W-1:0];
  endfunction

  // Queue a header of nwords words; optionally patch in a correct checksum
  task automatic push_header(input logic [3:0] ihl, input int unsigned nwords,
                             input bit good_cks, input bit end_last);
    logic [WORD_W-1:0] w[$];
    logic [WORD_W-1:0] w0;
    hdr_item_t         it;
    w0 = WORD_W'($urandom);
    w0[11:8] = ihl;
    w.push_back(w0);
    for (int unsigned i = 1; i < nwords; i++) w.push_back(WORD_W'($urandom));
    if (good_cks && nwords > CKS_WORD) w[CKS_WORD] = header_cks(w);
    for (int unsigned i = 0; i < nwords; i++) begin
      it.op    = 1'b0;
      it.first = (i == 0);
      it.word  = w[i];
      it.ends  = end_last && (i == nwords - 1);
      header_items.push_back(it);
    end
    words_sent += nwords;
  endtask

  task automatic push_word(input logic op, input logic first, input logic [WORD_W-1:0] word,
                           input logic ends);
    header_items.push_back('{op, first, word, ends});
    words_sent++;
    if (op) begin
      gen_open = 1'b0;
    end
  endtask

  // Pick one random packet shape; well-formed headers dominate
  task automatic add_random_packet();
    int unsigned pick;
    int unsigned ihl;
    int unsigned limit;
    pick = $urandom_range(99);
    ihl  = ($urandom_range(4) == 0) ? $urandom_range(15, 5) : $urandom_range(7, 5);
    if (pick < 55) begin
      push_header(4'(ihl), ihl * 2, 1'($urandom_range(1)), 1'($urandom_range(1)));
      gen_open = 1'b0;
      // Let payload words follow now and then; the block drops them
      if ($urandom_range(3) == 0)
        push_word(1'b0, 1'b0, WORD_W'($urandom), 1'($urandom_range(1)));
    end else if (pick < 65) begin
      push_header(4'($urandom_range(15)), $urandom_range(9, 1), 1'($urandom_range(1)),
                  1'b1);
      gen_open = 1'b0;
    end else if (pick < 75) begin
      ihl = $urandom_range(15, 6);
      push_header(4'(ihl), $urandom_range(ihl * 2 - 1, MIN_WORDS), 1'($urandom_range(1)),
                  1'b1);
      gen_open = 1'b0;
    end else if (pick < 83) begin
      push_header(4'($urandom_range(4)), MIN_WORDS, 1'b0, 1'($urandom_range(1)));
      gen_open = 1'b0;
    end else if (pick < 91) begin
      push_word(1'b1, 1'($urandom_range(1)), WORD_W'($urandom), 1'($urandom_range(1)));
    end else if (pick < 96) begin
      // Abandon mid-header; the next packet restarts the parse
      ihl   = $urandom_range(15);
      limit = (ihl >= IHL_MIN) ? ihl * 2 : MIN_WORDS;
      push_header(4'(ihl), $urandom_range(limit - 1, 1), 1'($urandom_range(1)), 1'b0);
      gen_open = 1'b1;
    end else if (!gen_open) begin
      push_word(1'b0, 1'b0, WORD_W'($urandom), 1'($urandom_range(1)));
    end else begin
      push_word(1'b1, 1'($urandom_range(1)), WORD_W'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // Driver: advance to the next item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (header_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        drv_item = header_items.pop_front();
        in_valid      <= 1'b1;
        in_op         <= drv_item.op;
        in_first_word <= drv_item.first;
        in_hdr_word   <= drv_item.word;
        in_data_ends  <= drv_item.ends;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted items, check accepted results, drive stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        track_header_word('{in_op, in_first_word, in_hdr_word, in_data_ends});
      if (out_valid && !out_stall) check_verdict();
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_verdicts.size());
      $display("[ipv4_header_checksum_fixer_core] ERROR");
      $finish;
    end
  end

  // Sequence: reset, directed packets, then one random batch per idling phase
  initial begin
    int unsigned sender_pct[NUM_PHASES];
    int unsigned recv_pct[NUM_PHASES];
    int unsigned target;
    int unsigned leftover;
    sender_pct = '{0, 76, 0, 27};
    recv_pct   = '{0, 0, 76, 27};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: marker, one-word short header, stray words at both extremes,
    // complete header with data ending on its last word, truncated options
    push_word(1'b1, 1'b1, 16'hffff, 1'b1);
    push_header(4'hf, 1, 1'b0, 1'b1);
    push_word(1'b0, 1'b0, 16'hffff, 1'b1);
    push_word(1'b0, 1'b0, 16'h0000, 1'b0);
    push_header(4'h5, 10, 1'b1, 1'b1);
    push_header(4'h6, 10, 1'b0, 1'b1);
    while (header_items.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(posedge clk);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = sender_pct[p];
      recv_stall_pct  = recv_pct[p];
      target = words_sent + PHASE_ITEMS;
      while (words_sent < target) add_random_packet();
      while (header_items.size() != 0 || in_valid || pending_verdicts.size() != 0)
        @(posedge clk);
    end

    // Drain: give the two-stage pipeline time to show any stray result
    repeat (16) @(posedge clk);
    leftover = pending_verdicts.size();
    $display("Ran %0d header items over %0d idling phases in %0d cycles", words_sent,
             NUM_PHASES, cycle_count);
    $display(
      "Verdicts non-ip/short/malformed/ok/fixed %0d/%0d/%0d/%0d/%0d; %0d bad, %0d missing",
      seen_verdicts[0], seen_verdicts[1], seen_verdicts[2], seen_verdicts[3],
      seen_verdicts[4], mismatch_count, leftover);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("[ipv4_header_checksum_fixer_core] OK");
    end else begin
      $display("[ipv4_header_checksum_fixer_core] ERROR");
    end
    $finish;
  end

endmodule
